// ===== sv/binary_to_roman_numeral_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_encoder assertion macros
// shared concurrent assertion forms for the encoder
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_ROMAN_NUMERAL_ENCODER_DEFINES_SVH
`define BINARY_TO_ROMAN_NUMERAL_ENCODER_DEFINES_SVH

// same-cycle implication
`define BRNE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BRNE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/brne_pkg.sv =====
// ----------------------------------------------------------------------------
// brne_pkg
// types, numeral term table and letter codes for the roman numeral encoder
// ----------------------------------------------------------------------------
package brne_pkg;

   localparam int VALUE_W    = 12;
   localparam int SYMBOL_W   = 7;
   localparam int TERM_COUNT = 13;
   localparam int TERM_IDX_W = 4;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

   localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'd0;
   localparam logic [SYMBOL_W-1:0] SYM_I    = 7'd73;
   localparam logic [SYMBOL_W-1:0] SYM_V    = 7'd86;
   localparam logic [SYMBOL_W-1:0] SYM_X    = 7'd88;
   localparam logic [SYMBOL_W-1:0] SYM_L    = 7'd76;
   localparam logic [SYMBOL_W-1:0] SYM_C    = 7'd67;
   localparam logic [SYMBOL_W-1:0] SYM_D    = 7'd68;
   localparam logic [SYMBOL_W-1:0] SYM_M    = 7'd77;

   typedef logic [VALUE_W-1:0]    value_type;
   typedef logic [SYMBOL_W-1:0]   symbol_type;
   typedef logic [TERM_IDX_W-1:0] term_idx_type;

   localparam value_type TERM_WEIGHT [TERM_COUNT] = '{
      12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
      12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
   };

   localparam symbol_type TERM_FIRST [TERM_COUNT] = '{
      SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X, SYM_L,
      SYM_X, SYM_X, SYM_I, SYM_V, SYM_I, SYM_I
   };

   localparam symbol_type TERM_SECOND [TERM_COUNT] = '{
      SYM_NONE, SYM_M, SYM_NONE, SYM_D, SYM_NONE, SYM_C, SYM_NONE,
      SYM_L, SYM_NONE, SYM_X, SYM_NONE, SYM_V, SYM_NONE
   };

   typedef struct packed {
      logic load;
      logic step;
   } brne_cmd_type;

   typedef struct packed {
      logic last;
   } brne_status_type;

endpackage

// ===== sv/brne_dp.sv =====
// ----------------------------------------------------------------------------
// brne_dp
// datapath: remaining value, pending second letter and letter output register
// ----------------------------------------------------------------------------
module brne_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  brne_pkg::value_type      req_value,
   input  brne_pkg::brne_cmd_type   cmd,
   output brne_pkg::brne_status_type status,
   output brne_pkg::symbol_type     rsp_symbol,
   output logic                     rsp_last,
   output logic                     rsp_error
);
   import brne_pkg::*;

   value_type    rest_ff, rest_in;
   logic         err_ff, err_in;
   logic         pend_ff, pend_in;
   symbol_type   pend_sym_ff, pend_sym_in;
   symbol_type   sym_ff, sym_in;
   logic         last_ff, last_in;
   logic         error_ff, error_in;
   term_idx_type term_idx;
   value_type    rest_sub;
   logic         has_second;

   // largest term not above the remaining value
   always_comb begin
      term_idx = '0;
      for (int i = TERM_COUNT - 1; i >= 0; i--) begin
         if (rest_ff >= TERM_WEIGHT[i]) begin
            term_idx = TERM_IDX_W'(i);
         end
      end
   end

   assign rest_sub   = rest_ff - TERM_WEIGHT[term_idx];
   assign has_second = (TERM_SECOND[term_idx] != SYM_NONE);

   always_comb begin
      rest_in     = rest_ff;
      err_in      = err_ff;
      pend_in     = pend_ff;
      pend_sym_in = pend_sym_ff;
      sym_in      = sym_ff;
      last_in     = last_ff;
      error_in    = error_ff;
      if (cmd.load) begin
         rest_in = req_value;
         err_in  = (req_value == '0) || (req_value > VALUE_MAX);
         pend_in = 1'b0;
      end else if (cmd.step) begin
         if (err_ff) begin
            sym_in   = SYM_NONE;
            last_in  = 1'b1;
            error_in = 1'b1;
         end else if (pend_ff) begin
            sym_in   = pend_sym_ff;
            last_in  = (rest_ff == '0);
            error_in = 1'b0;
            pend_in  = 1'b0;
         end else begin
            sym_in      = TERM_FIRST[term_idx];
            last_in     = !has_second && (rest_sub == '0);
            error_in    = 1'b0;
            rest_in     = rest_sub;
            pend_in     = has_second;
            pend_sym_in = TERM_SECOND[term_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         err_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         err_ff  <= err_in;
      end
      rest_ff     <= rest_in;
      pend_sym_ff <= pend_sym_in;
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      error_ff    <= error_in;
   end

   assign status.last = last_in;
   assign rsp_symbol  = sym_ff;
   assign rsp_last    = last_ff;
   assign rsp_error   = error_ff;

endmodule

// ===== sv/brne_ctrl.sv =====
// ----------------------------------------------------------------------------
// brne_ctrl
// controller: accepts one value, steps the datapath one letter per transaction
// ----------------------------------------------------------------------------
module brne_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  brne_pkg::brne_status_type status,
   output brne_pkg::brne_cmd_type    cmd
);
   import brne_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;
   logic valid_ff, valid_in;
   logic out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign cmd.load  = req_valid && req_ready;
   assign cmd.step  = (state_ff == ST_RUN) && out_free;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cmd.step) begin
               valid_in = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

// ===== sv/binary_to_roman_numeral_encoder.sv =====
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_encoder
// converts a 12-bit value to its roman numeral, one ascii letter per transaction
// ----------------------------------------------------------------------------
// Each accepted value yields 1 to 15 letter transactions, most significant
// letter first, the final one flagged by rsp_last. Values 0 and 4000..4095
// yield a single transaction with rsp_error set and rsp_symbol 0. One value is
// worked on at a time: the value is loaded, then with rsp_ready held high
// one letter per cycle passes through the single letter output register.
// A new value is accepted while the final letter of the previous one still
// waits on the output.
module binary_to_roman_numeral_encoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  brne_pkg::value_type  req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output brne_pkg::symbol_type rsp_symbol,
   output logic                 rsp_last,
   output logic                 rsp_error
);
   import brne_pkg::*;

   `include "binary_to_roman_numeral_encoder_defines.svh"

   brne_cmd_type    cmd;
   brne_status_type status;

   brne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   brne_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_value),
      .cmd        (cmd),
      .status     (status),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

   `BRNE_ASSERT_NOW(a_error_single, clock, reset, rsp_valid && rsp_error,
      rsp_last && (rsp_symbol == SYM_NONE), "error transaction not a lone zero")
   `BRNE_ASSERT_NOW(a_letter_legal, clock, reset, rsp_valid && !rsp_error,
      (rsp_symbol == SYM_I) || (rsp_symbol == SYM_V) || (rsp_symbol == SYM_X) ||
      (rsp_symbol == SYM_L) || (rsp_symbol == SYM_C) || (rsp_symbol == SYM_D) ||
      (rsp_symbol == SYM_M), "illegal numeral letter")
   `BRNE_ASSERT_NOW(a_accept_after_last, clock, reset, req_valid && req_ready,
      !rsp_valid || rsp_last, "value accepted mid numeral")
   `BRNE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
      !req_ready, "second value accepted while converting")

endmodule
